FILE: src/dcfb_pkg.sv
// Shared types and constants of the DDS command frame builder.
// Depends on nothing; every other file of the block but dcfb_if.sv imports it.
package dcfb_pkg;

    // Command opcodes.
    localparam logic [2:0] OP_FREQ  = 3'd0;
    localparam logic [2:0] OP_AMPL  = 3'd1;
    localparam logic [2:0] OP_PHASE = 3'd2;
    localparam logic [2:0] OP_QUAD  = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION_REG_ONE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUAD_AMPLITUDE   = 1'b1;

    localparam logic [23:0] FUNCTION_REG_ONE_RST = 24'hD00000;
    localparam logic [9:0]  QUAD_AMPLITUDE_RST   = 10'd867;

    // Serial port register addresses and fixed data bytes.
    localparam logic [7:0] ADDR_CSR   = 8'h00;
    localparam logic [7:0] ADDR_FR1   = 8'h01;
    localparam logic [7:0] ADDR_CFTW0 = 8'h04;
    localparam logic [7:0] ADDR_CPOW0 = 8'h05;
    localparam logic [7:0] ADDR_ACR   = 8'h06;
    localparam logic [7:0] CSR_CH0    = 8'h10;
    localparam logic [7:0] CSR_CH2_3  = 8'hC0;
    localparam logic [7:0] CSR_CH3    = 8'h80;
    localparam logic [15:0] ACR_ENABLE = 16'h1000;
    localparam logic [15:0] POW_90_DEG = 16'h1000;

    // FTW = floor(f * 2^32 / 500e6) = floor(f * 2^24 / 5^9), about f * 8.589934592.
    // The rounded-up reciprocal scaled by 2^50 is exact for every 29-bit f.
    localparam int unsigned FTW_SHIFT = 50;
    localparam logic [53:0] FTW_RECIP =
        54'(((83'd1 << 74) + 83'd1953124) / 83'd1953125);
    localparam logic [26:0] FTW_RECIP_LO = FTW_RECIP[26:0];
    localparam logic [26:0] FTW_RECIP_HI = FTW_RECIP[53:27];

    // POW = floor(deg * 16384 / 360) = floor(deg * 2048 / 45), exact for 9-bit deg.
    localparam int unsigned POW_SHIFT = 15;
    localparam logic [20:0] POW_RECIP = 21'(((32'd1 << 26) + 32'd44) / 32'd45);

    typedef enum logic [2:0] {
        KIND_FREQ,
        KIND_AMPL,
        KIND_PHASE,
        KIND_QUAD,
        KIND_INIT
    } dcfb_kind_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        dcfb_kind_t  kind;
        logic [7:0]  csr;
        logic [31:0] word;   // FTW, or FR1 value for init
        logic [15:0] half;   // ACR value or POW
    } dcfb_job_t;

endpackage

FILE: src/dcfb_if.sv
// Handshake channel interfaces of the DDS command frame builder.
// Depends on nothing.
interface dcfb_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [2:0]  channel;
    logic [28:0] frequency_hz;
    logic [9:0]  amplitude_scale;
    logic [8:0]  phase_deg;

    modport source (output valid, output opcode, output channel, output frequency_hz,
                    output amplitude_scale, output phase_deg, input ready);
    modport sink (input valid, input opcode, input channel, input frequency_hz,
                  input amplitude_scale, input phase_deg, output ready);
endinterface

interface dcfb_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       update_pulse;
    logic       last;

    modport source (output valid, output tx_byte, output frame_end, output update_pulse,
                    output last, input ready);
    modport sink (input valid, input tx_byte, input frame_end, input update_pulse,
                  input last, output ready);
endinterface

FILE: src/dds_command_frame_builder.sv
// Top level of the DDS command frame builder: front end, job queue and byte sequencer.
// Depends on dcfb_pkg, dcfb_if, dcfb_front, dcfb_fifo and dcfb_back.
//
// Each accepted command becomes the byte frames of a four-channel DDS serial
// port: a channel-select write and then the frequency, amplitude or phase word,
// the five-frame quadrature sequence, or the function register 1 write. Bytes
// leave at one per cycle, while the output is not stalled, through a registered
// output; a command has 7 bytes for frequency, 6 for amplitude, 5 for phase, 16
// for quadrature and 4 for init, and the byte sequencer sets the sustained rate.
// Commands are accepted one per cycle, while the front end is not stalled, into
// a two-stage front end (the FTW multiply is split into two partial products and
// summed in the next stage), wait in a QUEUE_DEPTH-entry queue and pass the job
// register to the output register. Frequency, amplitude and phase commands with
// a channel above 3, and unused opcodes, produce no bytes. Configuration writes
// take effect at the next command and are expected only while the block is idle.
module dds_command_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dcfb_cmd_if.sink                         cmd,
    dcfb_frame_if.source                     frame,
    input  logic                             cfg_we,
    input  logic [dcfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcfb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcfb_pkg::*;

    logic      job_push;
    dcfb_job_t job_in;
    logic      job_full;
    logic      job_pop;
    dcfb_job_t job_out;
    logic      job_avail;

    dcfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    dcfb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .not_empty (job_avail)
    );

    dcfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_avail),
        .job       (job_out),
        .job_pop   (job_pop),
        .frame     (frame)
    );

endmodule

FILE: src/dcfb_front.sv
// Front end: accepts commands, holds the configuration registers, classifies
// each command and computes its tuning words. Depends on dcfb_pkg and dcfb_if.
module dcfb_front (
    input  logic                             clk,
    input  logic                             rst_n,
    dcfb_cmd_if.sink                         cmd,
    input  logic                             cfg_we,
    input  logic [dcfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcfb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             job_valid,
    output dcfb_pkg::dcfb_job_t              job,
    input  logic                             job_full
);
    import dcfb_pkg::*;

    logic [23:0] fr1_reg;
    logic [9:0]  quad_amp_reg;

    // Stage 1: classified command and FTW partial products.
    logic        s1_valid_reg;
    dcfb_kind_t  s1_kind_reg;
    logic [7:0]  s1_csr_reg;
    logic [15:0] s1_half_reg;
    logic [23:0] s1_fr1_reg;
    logic [55:0] s1_pp_lo_reg;
    logic [55:0] s1_pp_hi_reg;

    // Stage 2: finished job.
    logic        s2_valid_reg;
    dcfb_job_t   s2_job_reg;

    logic        advance;
    logic        cmd_ok;
    dcfb_kind_t  kind;
    logic [15:0] half;
    logic [29:0] pow_prod;
    logic [82:0] ftw_sum;
    logic [31:0] ftw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr1_reg      <= FUNCTION_REG_ONE_RST;
            quad_amp_reg <= QUAD_AMPLITUDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FUNCTION_REG_ONE: fr1_reg      <= cfg_data[23:0];
                CFG_QUAD_AMPLITUDE:   quad_amp_reg <= cfg_data[9:0];
            endcase
        end
    end

    // The whole front pipeline moves together whenever the last stage can drain.
    assign advance   = !s2_valid_reg || !job_full;
    assign cmd.ready = advance;

    assign pow_prod = 30'(cmd.phase_deg) * 30'(POW_RECIP);

    always_comb
    begin
        cmd_ok = 1'b0;
        kind   = KIND_FREQ;
        half   = '0;
        unique case (cmd.opcode)
            OP_FREQ:
            begin
                cmd_ok = !cmd.channel[2];
                kind   = KIND_FREQ;
            end
            OP_AMPL:
            begin
                cmd_ok = !cmd.channel[2];
                kind   = KIND_AMPL;
                half   = ACR_ENABLE | 16'(cmd.amplitude_scale);
            end
            OP_PHASE:
            begin
                cmd_ok = !cmd.channel[2];
                kind   = KIND_PHASE;
                half   = 16'(pow_prod >> POW_SHIFT);
            end
            OP_QUAD:
            begin
                cmd_ok = 1'b1;
                kind   = KIND_QUAD;
                half   = ACR_ENABLE | 16'(quad_amp_reg);
            end
            OP_INIT:
            begin
                cmd_ok = 1'b1;
                kind   = KIND_INIT;
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= cmd.valid && cmd_ok;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg  <= kind;
            s1_csr_reg   <= 8'(CSR_CH0 << cmd.channel[1:0]);
            s1_half_reg  <= half;
            s1_fr1_reg   <= fr1_reg;
            s1_pp_lo_reg <= 56'(cmd.frequency_hz) * 56'(FTW_RECIP_LO);
            s1_pp_hi_reg <= 56'(cmd.frequency_hz) * 56'(FTW_RECIP_HI);
            s2_job_reg.kind <= s1_kind_reg;
            s2_job_reg.csr  <= s1_csr_reg;
            s2_job_reg.half <= s1_half_reg;
            s2_job_reg.word <= (s1_kind_reg == KIND_INIT) ? {8'h00, s1_fr1_reg} : ftw;
        end
    end

    assign ftw_sum = {s1_pp_hi_reg, 27'd0} + {27'd0, s1_pp_lo_reg};
    assign ftw     = ftw_sum[FTW_SHIFT +: 32];

    assign job_valid = s2_valid_reg;
    assign job       = s2_job_reg;

endmodule

FILE: src/dcfb_fifo.sv
// Short job queue between the front end and the byte sequencer.
// Depends on dcfb_pkg for the job record type.
module dcfb_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dcfb_pkg::dcfb_job_t push_data,
    output logic                full,
    input  logic                pop,
    output dcfb_pkg::dcfb_job_t pop_data,
    output logic                not_empty
);
    import dcfb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dcfb_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/dcfb_back.sv
// Byte sequencer: walks one queued job a byte per cycle, while the output is
// not stalled, into the output register. Depends on dcfb_pkg and dcfb_if.
module dcfb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  dcfb_pkg::dcfb_job_t job,
    output logic                job_pop,
    dcfb_frame_if.source        frame
);
    import dcfb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       update;
    } dcfb_byte_t;

    function automatic dcfb_byte_t frame_byte(dcfb_job_t j, logic [3:0] i);
        dcfb_byte_t b;
        b = '{value: 8'h00, frame_end: 1'b0, update: 1'b0};
        unique case (j.kind)
            KIND_FREQ, KIND_AMPL, KIND_PHASE:
            begin
                case (i)
                    4'd0: b.value = ADDR_CSR;
                    4'd1: b = '{value: j.csr, frame_end: 1'b1, update: 1'b0};
                    default: b.value = 8'h00;
                endcase
                if (j.kind == KIND_FREQ)
                begin
                    case (i)
                        4'd2: b.value = ADDR_CFTW0;
                        4'd3: b.value = j.word[31:24];
                        4'd4: b.value = j.word[23:16];
                        4'd5: b.value = j.word[15:8];
                        4'd6: b = '{value: j.word[7:0], frame_end: 1'b1, update: 1'b1};
                        default: ;
                    endcase
                end
                else if (j.kind == KIND_AMPL)
                begin
                    case (i)
                        4'd2: b.value = ADDR_ACR;
                        4'd3: b.value = 8'h00;
                        4'd4: b.value = j.half[15:8];
                        4'd5: b = '{value: j.half[7:0], frame_end: 1'b1, update: 1'b1};
                        default: ;
                    endcase
                end
                else
                begin
                    case (i)
                        4'd2: b.value = ADDR_CPOW0;
                        4'd3: b.value = j.half[15:8];
                        4'd4: b = '{value: j.half[7:0], frame_end: 1'b1, update: 1'b1};
                        default: ;
                    endcase
                end
            end
            KIND_QUAD:
            begin
                unique case (i)
                    4'd0:  b.value = ADDR_CSR;
                    4'd1:  b = '{value: CSR_CH2_3, frame_end: 1'b1, update: 1'b0};
                    4'd2:  b.value = ADDR_ACR;
                    4'd3:  b.value = 8'h00;
                    4'd4:  b.value = j.half[15:8];
                    4'd5:  b = '{value: j.half[7:0], frame_end: 1'b1, update: 1'b1};
                    4'd6:  b.value = ADDR_CFTW0;
                    4'd7:  b.value = j.word[31:24];
                    4'd8:  b.value = j.word[23:16];
                    4'd9:  b.value = j.word[15:8];
                    4'd10: b = '{value: j.word[7:0], frame_end: 1'b1, update: 1'b1};
                    4'd11: b.value = ADDR_CSR;
                    4'd12: b = '{value: CSR_CH3, frame_end: 1'b1, update: 1'b0};
                    4'd13: b.value = ADDR_CPOW0;
                    4'd14: b.value = POW_90_DEG[15:8];
                    4'd15: b = '{value: POW_90_DEG[7:0], frame_end: 1'b1, update: 1'b1};
                endcase
            end
            KIND_INIT:
            begin
                case (i)
                    4'd0: b.value = ADDR_FR1;
                    4'd1: b.value = j.word[23:16];
                    4'd2: b.value = j.word[15:8];
                    4'd3: b = '{value: j.word[7:0], frame_end: 1'b1, update: 1'b1};
                    default: b.value = 8'h00;
                endcase
            end
            default: b.value = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] last_index(dcfb_kind_t k);
        logic [3:0] n;
        unique case (k)
            KIND_FREQ:  n = 4'd6;
            KIND_AMPL:  n = 4'd5;
            KIND_PHASE: n = 4'd4;
            KIND_QUAD:  n = 4'd15;
            KIND_INIT:  n = 4'd3;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

    logic       cur_valid_reg;
    dcfb_job_t  cur_job_reg;
    logic [3:0] idx_reg;
    logic       out_valid_reg;
    dcfb_byte_t out_byte_reg;
    logic       out_last_reg;

    dcfb_byte_t info;
    logic       step;
    logic       is_last;
    logic       load;

    assign info    = frame_byte(cur_job_reg, idx_reg);
    assign is_last = (idx_reg == last_index(cur_job_reg.kind));
    assign step    = cur_valid_reg && (!out_valid_reg || frame.ready);
    assign load    = job_valid && (!cur_valid_reg || (step && is_last));
    assign job_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (step && is_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_job_reg <= job;
        end
        if (step)
        begin
            out_byte_reg <= info;
            out_last_reg <= is_last;
        end
    end

    assign frame.valid        = out_valid_reg;
    assign frame.tx_byte      = out_byte_reg.value;
    assign frame.frame_end    = out_byte_reg.frame_end;
    assign frame.update_pulse = out_byte_reg.update;
    assign frame.last         = out_last_reg;

endmodule
